FILE: rtl/kfg_pkg.sv
`default_nettype none
package kfg_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 16;
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 10;
  localparam int CFGW_W    = 11;

  localparam logic [CFGW_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [ROW_W-1:0]  HEIGHT_RESET = 16'd480;
  localparam logic [CFGW_W-1:0] WIDTH_MIN    = 11'd3;
  localparam logic [CFGW_W-1:0] WIDTH_MAX    = 11'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]  HEIGHT_MIN   = 16'd3;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [2:0] DIR_HORZ    = 3'd0;
  localparam logic [2:0] DIR_DIAG45  = 3'd1;
  localparam logic [2:0] DIR_VERT    = 3'd6;
  localparam logic [2:0] DIR_DIAGM45 = 3'd7;

  // Reciprocal of three, exact for inputs below 2048.
  localparam logic [SUM_W-1:0] RECIP3 = 10'd683;

  typedef struct packed {
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
  } geom_t;

  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] d;
    logic [PIX_W-1:0] f;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] h;
    logic [PIX_W-1:0] i;
  } win_t;

  typedef struct packed {
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic             interior;
    logic             last;
  } pos_t;

  function automatic logic [SUM_W-1:0] sum3(input logic [PIX_W-1:0] x,
                                            input logic [PIX_W-1:0] y,
                                            input logic [PIX_W-1:0] z);
    sum3 = SUM_W'(x) + SUM_W'(y) + SUM_W'(z);
  endfunction

  function automatic logic [SUM_W-1:0] absdiff(input logic [SUM_W-1:0] p,
                                               input logic [SUM_W-1:0] n);
    absdiff = (p >= n) ? (p - n) : (n - p);
  endfunction

  function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] v);
    logic [2*SUM_W-1:0] prod;
    prod = (2*SUM_W)'(v) * (2*SUM_W)'(RECIP3);
    div3 = prod[18:11];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/kirsch_four_direction_gradient_core.sv
// Channel  | Handshake                    | Word
// ---------+------------------------------+-----------------------------------------
// in       | in_valid / in_ready          | in_pixel_value
// out      | out_valid / out_ready        | grad norm, direction, row, col, last
// cfg      | psel penable pwrite pready   | paddr, pwdata, prdata
//
// One pixel word is accepted per cycle while out_ready does not hold the pipeline back.
// The line store read is registered, then the window, then the mask sums, then the result.
// Reset clears the position counters and stage valid bits; no clearing pass is needed.
// A stalled result register holds the pipeline only as far back as there are full stages.
`default_nettype none
module kirsch_four_direction_gradient_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [kfg_pkg::PIX_W-1:0] in_pixel_value,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [kfg_pkg::PIX_W-1:0] out_grad_norm,
  output      logic [2:0]                out_grad_direction,
  output      logic [kfg_pkg::ROW_W-1:0] out_row,
  output      logic [kfg_pkg::COL_W-1:0] out_col,
  output      logic                      out_frame_last,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready
);

  kfg_pkg::geom_t geom;
  kfg_pkg::win_t  win;
  kfg_pkg::pos_t  pos;
  logic           restart;
  logic           s2_valid;
  logic           s2_ready;

  kfg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom),
    .restart (restart)
  );

  kfg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .geom           (geom),
    .restart        (restart),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .s2_valid       (s2_valid),
    .s2_ready       (s2_ready),
    .win            (win),
    .pos            (pos)
  );

  kfg_mask u_mask (
    .clk                (clk),
    .rst_n              (rst_n),
    .s2_valid           (s2_valid),
    .s2_ready           (s2_ready),
    .win                (win),
    .pos                (pos),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_grad_norm      (out_grad_norm),
    .out_grad_direction (out_grad_direction),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_frame_last     (out_frame_last)
  );

endmodule
`default_nettype wire

FILE: rtl/kfg_ram.sv
`default_nettype none
module kfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kfg_cfg.sv
`default_nettype none
module kfg_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output      logic [31:0]   prdata,
  output      logic          pready,
  output      kfg_pkg::geom_t geom,
  output      logic          restart
);

  logic [kfg_pkg::CFGW_W-1:0] width_r;
  logic [kfg_pkg::ROW_W-1:0]  height_r;
  logic [kfg_pkg::COL_W-1:0]  wm1_r;
  logic [kfg_pkg::ROW_W-1:0]  hm1_r;
  logic [kfg_pkg::CFGW_W-1:0] wr_width;
  logic [kfg_pkg::ROW_W-1:0]  wr_height;
  logic [kfg_pkg::CFGW_W-1:0] eff_w;
  logic [kfg_pkg::ROW_W-1:0]  eff_h;
  logic                       wr;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign restart   = wr;
  assign wr_width  = pwdata[kfg_pkg::CFGW_W-1:0];
  assign wr_height = pwdata[kfg_pkg::ROW_W-1:0];

  always_comb begin
    if (wr_width < kfg_pkg::WIDTH_MIN) begin
      eff_w = kfg_pkg::WIDTH_MIN;
    end else if (wr_width > kfg_pkg::WIDTH_MAX) begin
      eff_w = kfg_pkg::WIDTH_MAX;
    end else begin
      eff_w = wr_width;
    end
    eff_h = (wr_height < kfg_pkg::HEIGHT_MIN) ? kfg_pkg::HEIGHT_MIN : wr_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= kfg_pkg::WIDTH_RESET;
      height_r <= kfg_pkg::HEIGHT_RESET;
      wm1_r    <= kfg_pkg::COL_W'(kfg_pkg::WIDTH_RESET - 11'd1);
      hm1_r    <= kfg_pkg::HEIGHT_RESET - 16'd1;
    end else if (wr) begin
      unique case (paddr[2])
        kfg_pkg::REG_FRAME_WIDTH: begin
          width_r <= wr_width;
          wm1_r   <= kfg_pkg::COL_W'(eff_w - 11'd1);
        end
        kfg_pkg::REG_FRAME_HEIGHT: begin
          height_r <= wr_height;
          hm1_r    <= eff_h - 16'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      kfg_pkg::REG_FRAME_WIDTH:  prdata = 32'(width_r);
      kfg_pkg::REG_FRAME_HEIGHT: prdata = 32'(height_r);
      default:                   prdata = 32'd0;
    endcase
  end

  assign geom.wm1 = wm1_r;
  assign geom.hm1 = hm1_r;

endmodule
`default_nettype wire

FILE: rtl/kfg_front.sv
`default_nettype none
module kfg_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire kfg_pkg::geom_t            geom,
  input  wire logic                      restart,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [kfg_pkg::PIX_W-1:0] in_pixel_value,
  output      logic                      s2_valid,
  input  wire logic                      s2_ready,
  output      kfg_pkg::win_t             win,
  output      kfg_pkg::pos_t             pos
);

  logic [kfg_pkg::COL_W-1:0] col_r;
  logic [kfg_pkg::ROW_W-1:0] row_r;
  logic                      s1_v_r;
  logic [kfg_pkg::PIX_W-1:0] s1_px_r;
  logic [kfg_pkg::COL_W-1:0] s1_col_r;
  logic [kfg_pkg::ROW_W-1:0] s1_row_r;
  logic                      s2_v_r;
  kfg_pkg::win_t             win_r;
  logic [kfg_pkg::PIX_W-1:0] e_r;
  kfg_pkg::pos_t             pos_r;
  kfg_pkg::pos_t             pos_nxt;
  logic [kfg_pkg::PIX_W-1:0] up_rd;
  logic [kfg_pkg::PIX_W-1:0] mid_rd;
  logic                      acc_in;
  logic                      adv_s1;
  logic                      emit;
  logic                      col_end;

  assign adv_s1   = s1_v_r && (!s2_v_r || s2_ready);
  assign in_ready = !s1_v_r || adv_s1;
  assign acc_in   = in_valid && in_ready;
  assign col_end  = (col_r == geom.wm1);

  kfg_ram #(.WIDTH(kfg_pkg::PIX_W), .DEPTH(kfg_pkg::MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (adv_s1),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .re    (acc_in),
    .raddr (col_r),
    .rdata (up_rd)
  );

  kfg_ram #(.WIDTH(kfg_pkg::PIX_W), .DEPTH(kfg_pkg::MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (adv_s1),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (acc_in),
    .raddr (col_r),
    .rdata (mid_rd)
  );

  always_comb begin
    emit = (s1_row_r >= 16'd2) || ((s1_row_r == 16'd1) && (s1_col_r != '0));
    if (s1_col_r == '0) begin
      pos_nxt.orow = s1_row_r - 16'd2;
      pos_nxt.ocol = geom.wm1;
    end else begin
      pos_nxt.orow = s1_row_r - 16'd1;
      pos_nxt.ocol = s1_col_r - 10'd1;
    end
    pos_nxt.interior = (pos_nxt.orow != '0) && (pos_nxt.ocol != '0) &&
                       (pos_nxt.ocol != geom.wm1);
    pos_nxt.last     = (s1_row_r == geom.hm1) && (s1_col_r == geom.wm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (restart) begin
        col_r <= '0;
        row_r <= '0;
      end else if (acc_in) begin
        if (col_end) begin
          col_r <= '0;
          row_r <= (row_r == geom.hm1) ? '0 : row_r + 16'd1;
        end else begin
          col_r <= col_r + 10'd1;
        end
      end
      if (acc_in) begin
        s1_v_r <= 1'b1;
      end else if (adv_s1) begin
        s1_v_r <= 1'b0;
      end
      if (adv_s1) begin
        s2_v_r <= emit;
      end else if (s2_ready) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_px_r  <= in_pixel_value;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
    if (adv_s1) begin
      win_r.a <= win_r.b;
      win_r.b <= win_r.c;
      win_r.c <= up_rd;
      win_r.d <= e_r;
      e_r     <= win_r.f;
      win_r.f <= mid_rd;
      win_r.g <= win_r.h;
      win_r.h <= win_r.i;
      win_r.i <= s1_px_r;
      pos_r   <= pos_nxt;
    end
  end

  assign s2_valid = s2_v_r;
  assign win      = win_r;
  assign pos      = pos_r;

endmodule
`default_nettype wire

FILE: rtl/kfg_mask.sv
`default_nettype none
module kfg_mask (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      s2_valid,
  output      logic                      s2_ready,
  input  wire kfg_pkg::win_t             win,
  input  wire kfg_pkg::pos_t             pos,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [kfg_pkg::PIX_W-1:0] out_grad_norm,
  output      logic [2:0]                out_grad_direction,
  output      logic [kfg_pkg::ROW_W-1:0] out_row,
  output      logic [kfg_pkg::COL_W-1:0] out_col,
  output      logic                      out_frame_last
);

  logic                      v3_r;
  logic [kfg_pkg::SUM_W-1:0] rh_r, r45_r, rv_r, rm45_r;
  kfg_pkg::pos_t             pos3_r;
  logic                      vo_r;
  logic [kfg_pkg::PIX_W-1:0] norm_r;
  logic [2:0]                dir_r;
  logic [kfg_pkg::ROW_W-1:0] row_r;
  logic [kfg_pkg::COL_W-1:0] col_r;
  logic                      last_r;
  logic                      adv_o;
  logic                      adv_3;
  logic [kfg_pkg::PIX_W-1:0] qh, q45, qv, qm45;
  logic [kfg_pkg::PIX_W-1:0] norm_nxt;
  logic [2:0]                dir_nxt;

  assign adv_o    = v3_r && (!vo_r || out_ready);
  assign s2_ready = !v3_r || adv_o;
  assign adv_3    = s2_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (adv_3) begin
      rh_r   <= kfg_pkg::absdiff(kfg_pkg::sum3(win.c, win.f, win.i),
                                 kfg_pkg::sum3(win.a, win.d, win.g));
      r45_r  <= kfg_pkg::absdiff(kfg_pkg::sum3(win.b, win.c, win.f),
                                 kfg_pkg::sum3(win.d, win.g, win.h));
      rv_r   <= kfg_pkg::absdiff(kfg_pkg::sum3(win.g, win.h, win.i),
                                 kfg_pkg::sum3(win.a, win.b, win.c));
      rm45_r <= kfg_pkg::absdiff(kfg_pkg::sum3(win.f, win.h, win.i),
                                 kfg_pkg::sum3(win.a, win.b, win.d));
      pos3_r <= pos;
    end
  end

  always_comb begin
    qh       = kfg_pkg::div3(rh_r);
    q45      = kfg_pkg::div3(r45_r);
    qv       = kfg_pkg::div3(rv_r);
    qm45     = kfg_pkg::div3(rm45_r);
    norm_nxt = qh;
    dir_nxt  = kfg_pkg::DIR_HORZ;
    if (q45 > norm_nxt) begin
      norm_nxt = q45;
      dir_nxt  = kfg_pkg::DIR_DIAG45;
    end
    if (qv > norm_nxt) begin
      norm_nxt = qv;
      dir_nxt  = kfg_pkg::DIR_VERT;
    end
    if (qm45 > norm_nxt) begin
      norm_nxt = qm45;
      dir_nxt  = kfg_pkg::DIR_DIAGM45;
    end
    if (!pos3_r.interior) begin
      norm_nxt = '0;
      dir_nxt  = kfg_pkg::DIR_HORZ;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      norm_r <= norm_nxt;
      dir_r  <= dir_nxt;
      row_r  <= pos3_r.orow;
      col_r  <= pos3_r.ocol;
      last_r <= pos3_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv_3) begin
        v3_r <= 1'b1;
      end else if (adv_o) begin
        v3_r <= 1'b0;
      end
      if (adv_o) begin
        vo_r <= 1'b1;
      end else if (out_ready) begin
        vo_r <= 1'b0;
      end
    end
  end

  assign out_valid          = vo_r;
  assign out_grad_norm      = norm_r;
  assign out_grad_direction = dir_r;
  assign out_row            = row_r;
  assign out_col            = col_r;
  assign out_frame_last     = last_r;

endmodule
`default_nettype wire

FILE: rtl/kfg_checker.sv
`default_nettype none
module kfg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_grad_norm,
  input wire logic [2:0]  out_grad_direction,
  input wire logic [15:0] out_row,
  input wire logic [9:0]  out_col,
  input wire logic        out_frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_grad_norm) &&
      $stable(out_grad_direction) && $stable(out_row) && $stable(out_col) &&
      $stable(out_frame_last))
    else $error("result word changed while stalled");

  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_grad_norm == 8'd0) |-> out_grad_direction == 3'd0)
    else $error("zero norm with a nonzero direction");

  a_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_row == 16'd0) || (out_col == 10'd0)) |->
      (out_grad_norm == 8'd0) && (out_grad_direction == 3'd0))
    else $error("border pixel with a nonzero result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind kirsch_four_direction_gradient_core kfg_checker u_kfg_checker (.*);
`default_nettype wire

FILE: tb/tb_kirsch_four_direction_gradient_core.sv
`timescale 1ns / 1ps
module tb_kirsch_four_direction_gradient_core;

  typedef struct packed {
    logic [kfg_pkg::PIX_W-1:0] norm;
    logic [2:0]                dir;
    logic [kfg_pkg::ROW_W-1:0] row;
    logic [kfg_pkg::COL_W-1:0] col;
    logic                      last;
  } grad_t;

  typedef struct packed {
    logic [kfg_pkg::PIX_W-1:0] pixel;
    logic                      has_want;
    grad_t                     want;
  } pixel_row_t;

  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 520;
  localparam int WIDE_ITEMS    = 40;
  localparam int MAX_PRINTS    = 100;
  localparam int DIRECTED_LEN  = 24;
  localparam int SECOND_FRAME  = 15;

  localparam logic [2:0] ADDR_FRAME_WIDTH  = {kfg_pkg::REG_FRAME_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_FRAME_HEIGHT = {kfg_pkg::REG_FRAME_HEIGHT, 2'b00};

  // A 3x5 frame with one interior pixel per mask family, then a 3x3 frame.
  localparam pixel_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{8'd0,   1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd255, 1'b1, '{8'd0,   kfg_pkg::DIR_HORZ,    16'd0, 10'd0, 1'b0}},
    '{8'd255, 1'b1, '{8'd0,   kfg_pkg::DIR_HORZ,    16'd0, 10'd1, 1'b0}},
    '{8'd0,   1'b1, '{8'd0,   kfg_pkg::DIR_HORZ,    16'd0, 10'd2, 1'b0}},
    '{8'd0,   1'b1, '{8'd0,   kfg_pkg::DIR_HORZ,    16'd1, 10'd0, 1'b0}},
    '{8'd255, 1'b1, '{8'd255, kfg_pkg::DIR_HORZ,    16'd1, 10'd1, 1'b0}},
    '{8'd0,   1'b1, '{8'd0,   kfg_pkg::DIR_HORZ,    16'd1, 10'd2, 1'b0}},
    '{8'd0,   1'b1, '{8'd0,   kfg_pkg::DIR_HORZ,    16'd2, 10'd0, 1'b0}},
    '{8'd0,   1'b1, '{8'd255, kfg_pkg::DIR_DIAG45,  16'd2, 10'd1, 1'b0}},
    '{8'd255, 1'b1, '{8'd0,   kfg_pkg::DIR_HORZ,    16'd2, 10'd2, 1'b0}},
    '{8'd255, 1'b1, '{8'd0,   kfg_pkg::DIR_HORZ,    16'd3, 10'd0, 1'b0}},
    '{8'd255, 1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd255, 1'b1, '{8'd255, kfg_pkg::DIR_DIAGM45, 16'd1, 10'd1, 1'b1}}
  };

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic [kfg_pkg::PIX_W-1:0]  in_pixel_value = '0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic [kfg_pkg::PIX_W-1:0]  out_grad_norm;
  logic [2:0]                 out_grad_direction;
  logic [kfg_pkg::ROW_W-1:0]  out_row;
  logic [kfg_pkg::COL_W-1:0]  out_col;
  logic                       out_frame_last;
  logic                       psel           = 1'b0;
  logic                       penable        = 1'b0;
  logic                       pwrite         = 1'b0;
  logic [2:0]                 paddr          = '0;
  logic [31:0]                pwdata         = '0;
  logic [31:0]                prdata;
  logic                       pready;

  logic [kfg_pkg::CFGW_W-1:0] frame_width_reg  = 11'd640;
  logic [kfg_pkg::ROW_W-1:0]  frame_height_reg = 16'd480;
  int unsigned                next_col = 0;
  int unsigned                next_row = 0;
  logic [kfg_pkg::PIX_W-1:0]  upper_line [kfg_pkg::MAX_WIDTH] = '{default: '0};
  logic [kfg_pkg::PIX_W-1:0]  middle_line [kfg_pkg::MAX_WIDTH] = '{default: '0};
  logic [kfg_pkg::PIX_W-1:0]  window [3][3] = '{default: '{default: '0}};

  grad_t expected_grads [$];
  int    mismatch_count = 0;
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  bit    hold_request   = 1'b0;
  bit    input_offered  = 1'b0;

  kirsch_four_direction_gradient_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pixel_value     (in_pixel_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_grad_norm      (out_grad_norm),
    .out_grad_direction (out_grad_direction),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_frame_last     (out_frame_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int working_width();
    if (frame_width_reg < kfg_pkg::WIDTH_MIN) return kfg_pkg::WIDTH_MIN;
    if (frame_width_reg > kfg_pkg::WIDTH_MAX) return kfg_pkg::WIDTH_MAX;
    return frame_width_reg;
  endfunction

  function automatic int working_height();
    return (frame_height_reg < kfg_pkg::HEIGHT_MIN) ? kfg_pkg::HEIGHT_MIN : frame_height_reg;
  endfunction

  function automatic int third_of_abs(input int v);
    return ((v < 0) ? -v : v) / 3;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("ERROR t=%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic predict_gradient(input logic [kfg_pkg::PIX_W-1:0] px, output bit emitted,
                                  output grad_t g);
    int w, hgt, c, r, best, resp;
    int a, b, cr, d, f, gl, hb, ir;
    logic [kfg_pkg::PIX_W-1:0] up, mid;
    w = working_width();
    hgt = working_height();
    c = next_col;
    r = next_row;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = px;
    for (int k = 0; k < 3; k++) begin
      window[k][0] = window[k][1];
      window[k][1] = window[k][2];
    end
    window[0][2] = up;
    window[1][2] = mid;
    window[2][2] = px;
    emitted = (r >= 2) || (r == 1 && c >= 1);
    g = '0;
    if (emitted) begin
      if (c == 0) begin
        g.row = kfg_pkg::ROW_W'(r - 2);
        g.col = kfg_pkg::COL_W'(w - 1);
      end else begin
        g.row = kfg_pkg::ROW_W'(r - 1);
        g.col = kfg_pkg::COL_W'(c - 1);
      end
      if (g.row >= 1 && g.row + 1 < hgt && g.col >= 1 && g.col + 1 < w) begin
        a = window[0][0];
        b = window[0][1];
        cr = window[0][2];
        d = window[1][0];
        f = window[1][2];
        gl = window[2][0];
        hb = window[2][1];
        ir = window[2][2];
        best = third_of_abs((cr + f + ir) - (a + d + gl));
        g.dir = kfg_pkg::DIR_HORZ;
        resp = third_of_abs((b + cr + f) - (d + gl + hb));
        if (resp > best) begin
          best = resp;
          g.dir = kfg_pkg::DIR_DIAG45;
        end
        resp = third_of_abs((gl + hb + ir) - (a + b + cr));
        if (resp > best) begin
          best = resp;
          g.dir = kfg_pkg::DIR_VERT;
        end
        resp = third_of_abs((f + hb + ir) - (a + b + d));
        if (resp > best) begin
          best = resp;
          g.dir = kfg_pkg::DIR_DIAGM45;
        end
        g.norm = kfg_pkg::PIX_W'(best);
      end
      g.last = (r + 1 >= hgt) && (c + 1 >= w);
    end
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= hgt) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endtask

  task automatic release_input();
    if (input_offered) in_valid <= 1'b0;
    input_offered = 1'b0;
  endtask

  task automatic offer_pixel(input logic [kfg_pkg::PIX_W-1:0] px, input bit has_want,
                             input grad_t want);
    int gap;
    bit emitted;
    grad_t g;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      release_input();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= px;
    input_offered = 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_gradient(px, emitted, g);
    if (has_want) expected_grads.push_back(want);
    else if (emitted) expected_grads.push_back(g);
  endtask

  task automatic drain_results(input int extra);
    release_input();
    do @(posedge clk); while (expected_grads.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    rdata = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_frame_reg(input logic idx, input logic [31:0] want);
    logic [31:0] got;
    apb_cycle(1'b0, (idx == kfg_pkg::REG_FRAME_WIDTH) ? ADDR_FRAME_WIDTH : ADDR_FRAME_HEIGHT,
              '0, got);
    if (got !== want) flag_mismatch($sformatf("register %0d read %0d, want %0d", idx, got, want));
  endtask

  task automatic program_frame_reg(input logic idx, input logic [31:0] value);
    logic [31:0] unused_rd;
    apb_cycle(1'b1, (idx == kfg_pkg::REG_FRAME_WIDTH) ? ADDR_FRAME_WIDTH : ADDR_FRAME_HEIGHT,
              value, unused_rd);
    if (idx == kfg_pkg::REG_FRAME_WIDTH) frame_width_reg = value[kfg_pkg::CFGW_W-1:0];
    else frame_height_reg = value[kfg_pkg::ROW_W-1:0];
    next_col = 0;
    next_row = 0;
    check_frame_reg(idx, (idx == kfg_pkg::REG_FRAME_WIDTH) ? 32'(frame_width_reg) :
                                                              32'(frame_height_reg));
  endtask

  always @(posedge clk) begin
    grad_t seen;
    grad_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_grad_norm, out_grad_direction, out_row, out_col, out_frame_last};
      if (expected_grads.size() == 0) begin
        flag_mismatch($sformatf("unexpected word norm %0d dir %0d row %0d col %0d last %0d",
                                seen.norm, seen.dir, seen.row, seen.col, seen.last));
      end else begin
        want = expected_grads.pop_front();
        if (seen !== want) begin
          flag_mismatch($sformatf(
            "got norm %0d dir %0d row %0d col %0d last %0d, want %0d %0d %0d %0d %0d",
            seen.norm, seen.dir, seen.row, seen.col, seen.last,
            want.norm, want.dir, want.row, want.col, want.last));
        end
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int count, kind, random_items, phase, wv, hv;
    logic [kfg_pkg::PIX_W-1:0] px;
    random_items = 0;
    phase = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_frame_reg(kfg_pkg::REG_FRAME_WIDTH, 32'd640);
    check_frame_reg(kfg_pkg::REG_FRAME_HEIGHT, 32'd480);

    program_frame_reg(kfg_pkg::REG_FRAME_WIDTH, 32'd3);
    program_frame_reg(kfg_pkg::REG_FRAME_HEIGHT, 32'd5);
    for (int k = 0; k < DIRECTED_LEN; k++) begin
      if (k == SECOND_FRAME) begin
        drain_results(SETTLE_CYCLES);
        program_frame_reg(kfg_pkg::REG_FRAME_HEIGHT, 32'd3);
      end
      offer_pixel(DIRECTED_ROWS[k].pixel, DIRECTED_ROWS[k].has_want, DIRECTED_ROWS[k].want);
    end

    drain_results(SETTLE_CYCLES);
    program_frame_reg(kfg_pkg::REG_FRAME_WIDTH, 32'hFFFF_F7FF);
    program_frame_reg(kfg_pkg::REG_FRAME_HEIGHT, 32'hFFFF_0000);
    for (int n = 0; n < WIDE_ITEMS; n++) offer_pixel(kfg_pkg::PIX_W'($urandom), 1'b0, '0);

    drain_results(SETTLE_CYCLES);
    program_frame_reg(kfg_pkg::REG_FRAME_WIDTH, 32'd1024);
    program_frame_reg(kfg_pkg::REG_FRAME_HEIGHT, 32'd65535);

    drain_results(SETTLE_CYCLES);
    program_frame_reg(kfg_pkg::REG_FRAME_WIDTH, 32'd3);
    for (int n = 0; n < 60; n++) offer_pixel(kfg_pkg::PIX_W'($urandom), 1'b0, '0);

    while (random_items < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct = 7;
          recv_stall_pct = 7;
        end
      endcase
      drain_results(SETTLE_CYCLES);
      wv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      if (phase < 2 || $urandom_range(0, 3) != 0) program_frame_reg(kfg_pkg::REG_FRAME_WIDTH, wv);
      if (phase < 2 || $urandom_range(0, 3) != 0) program_frame_reg(kfg_pkg::REG_FRAME_HEIGHT, hv);
      count = working_width() * working_height();
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
      else count = count * $urandom_range(1, 2);
      if (phase == 3) begin
        if (count < 80) count = 80;
        hold_request = 1'b1;
      end
      kind = $urandom_range(0, 2);
      for (int n = 0; n < count; n++) begin
        if (phase == 6 && n == count / 2) drain_results(0);
        case (kind)
          0: px = kfg_pkg::PIX_W'($urandom_range(0, 255));
          1: px = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
          default: px = kfg_pkg::PIX_W'(120 + $urandom_range(0, 15));
        endcase
        offer_pixel(px, 1'b0, '0);
      end
      random_items += count;
      phase++;
    end

    drain_results(SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
